// ----- rtl/tchae_pkg.sv -----
// Shared constants, types and entry layout of the tagged cache hit-age eviction unit.
package tchae_pkg;

	// Table geometry.
	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int SCAN_W  = $clog2(ENTRIES + 2);

	// Field widths.
	localparam int HASH_W  = 64;
	localparam int FONT_W  = 16;
	localparam int HITS_W  = 24;
	localparam int STAMP_W = 32;

	localparam logic [HITS_W-1:0]  HIT_MAX      = {HITS_W{1'b1}};
	localparam logic [STAMP_W-1:0] SCORE_WEIGHT = 32'd1000;

	// Command codes.
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Lookup key.
	typedef struct packed {
		logic [HASH_W-1:0] text_hash;
		logic [FONT_W-1:0] font_id;
		logic [FONT_W-1:0] font_size;
	} key_t;

	// One stored entry of the tag store.
	typedef struct packed {
		key_t               key;
		logic [HITS_W-1:0]  hits;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Scan beat handed from the sequencer to the score unit.
	typedef struct packed {
		logic             pv;
		logic [IDX_W-1:0] idx;
		logic             vbit;
	} scan_in_t;

	// Outcome of one full scan.
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  hit_slot;
		logic [HITS_W-1:0] hit_hits;
		logic              free_found;
		logic [IDX_W-1:0]  free_slot;
		logic [IDX_W-1:0]  best_slot;
	} scan_res_t;

endpackage

// ----- rtl/tchae_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tchae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/tchae_score.sv -----
// Shared tag compare and score unit that folds one entry per cycle into the scan result.
module tchae_score import tchae_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  key_t               key,
	input  logic [STAMP_W-1:0] acc,
	input  scan_in_t           scan,
	input  entry_t             entry,
	output scan_res_t          res
);

	logic               pv_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic               vbit_s2;
	logic               match_s2;
	logic [STAMP_W-1:0] score_s2;
	logic [HITS_W-1:0]  hits_s2;

	logic               found_q;
	logic [IDX_W-1:0]   hit_slot_q;
	logic [HITS_W-1:0]  hit_hits_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_slot_q;
	logic [IDX_W-1:0]   best_slot_q;
	logic [STAMP_W-1:0] best_score_q;

	logic [STAMP_W-1:0] weighted;

	// The score is hits times the weight plus the age, all modulo 2^32.
	assign weighted = STAMP_W'(STAMP_W'(entry.hits) * SCORE_WEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s2 <= 1'b0;
		end else begin
			pv_s2 <= scan.pv;
		end
	end

	// Compare and score stage.
	always_ff @(posedge clk) begin
		idx_s2   <= scan.idx;
		vbit_s2  <= scan.vbit;
		match_s2 <= scan.vbit && (entry.key == key);
		score_s2 <= weighted + (acc - entry.stamp);
		hits_s2  <= entry.hits;
	end

	// Accumulate the first match, the lowest free slot and the lowest-score slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (start) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (pv_s2) begin
			if (match_s2 && !found_q) begin
				found_q <= 1'b1;
			end
			if (!vbit_s2 && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pv_s2) begin
			if (match_s2 && !found_q) begin
				hit_slot_q <= idx_s2;
				hit_hits_q <= hits_s2;
			end
			if (!vbit_s2 && !free_found_q) begin
				free_slot_q <= idx_s2;
			end
			if (idx_s2 == '0 || score_s2 < best_score_q) begin
				best_slot_q  <= idx_s2;
				best_score_q <= score_s2;
			end
		end
	end

	assign res.found      = found_q;
	assign res.hit_slot   = hit_slot_q;
	assign res.hit_hits   = hit_hits_q;
	assign res.free_found = free_found_q;
	assign res.free_slot  = free_slot_q;
	assign res.best_slot  = best_slot_q;

endmodule

// ----- rtl/tagged_cache_hit_age_eviction_unit.sv -----
// Top level: sequencer, valid bits, tag store RAM and result register of the cache unit.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid, in_stall   | cmd, text_hash, font_id, font_size
//  out     | output    | out_valid, out_stall | hit, slot, evicted, entry_count
//
// A lookup scans every entry through one RAM read port and the shared score unit,
// one entry a cycle, then writes the chosen slot; a clear skips the scan. The next
// beat is taken once the result is loaded and the sequencer is idle again; in_stall
// is high while an item is at work.
// Reset clears all valid bits, the entry count and the access counter at once.
// A result waits in the output register while out_stall is high; the next beat
// may be accepted meanwhile, and its result holds until the register frees.
module tagged_cache_hit_age_eviction_unit import tchae_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          cmd,
	input  logic [63:0]   text_hash,
	input  logic [15:0]   font_id,
	input  logic [15:0]   font_size,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          hit,
	output logic [5:0]    slot,
	output logic          evicted,
	output logic [6:0]    entry_count
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]         state_q;
	logic [SCAN_W-1:0]  scan_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAMP_W-1:0] acc_q;
	key_t               key_q;

	logic               res_hit_q;
	logic [5:0]         res_slot_q;
	logic               res_evicted_q;
	logic [6:0]         res_count_q;

	logic               pv_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               vbit_s1;

	logic               in_acc;
	logic               out_free;
	logic               issue;
	logic [IDX_W-1:0]   raddr;
	entry_t             rd_entry;
	entry_t             wr_entry;
	scan_in_t           scan;
	scan_res_t          sres;
	logic [IDX_W-1:0]   upd_slot;
	logic               upd_evict;
	logic               upd_grow;
	logic [HITS_W-1:0]  upd_hits;
	logic [CNT_W-1:0]   count_next;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign issue    = (state_q == ST_SCAN) && (scan_q < SCAN_W'(ENTRIES));
	assign raddr    = scan_q[IDX_W-1:0];

	// Update decision from the finished scan.
	always_comb begin
		upd_evict  = !sres.found && !sres.free_found;
		upd_grow   = !sres.found && sres.free_found;
		count_next = upd_grow ? count_q + 1'b1 : count_q;
		if (sres.found) begin
			upd_slot = sres.hit_slot;
			upd_hits = (sres.hit_hits == HIT_MAX) ? sres.hit_hits : sres.hit_hits + 1'b1;
		end else begin
			upd_slot = sres.free_found ? sres.free_slot : sres.best_slot;
			upd_hits = HITS_W'(1);
		end
		wr_entry.key   = key_q;
		wr_entry.hits  = upd_hits;
		wr_entry.stamp = acc_q + 1'b1;
	end

	// Sequencer and table control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			scan_q    <= '0;
			valid_q   <= '0;
			count_q   <= '0;
			acc_q     <= '0;
			out_valid <= 1'b0;
			pv_s1     <= 1'b0;
		end else begin
			pv_s1 <= issue;
			// The output register loads a finished result or empties once taken.
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						scan_q <= '0;
						if (cmd == CMD_CLEAR) begin
							valid_q <= '0;
							count_q <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == SCAN_W'(ENTRIES + 1)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					valid_q[upd_slot] <= 1'b1;
					count_q           <= count_next;
					acc_q             <= acc_q + 1'b1;
					state_q           <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Key capture, result staging and the output register.
	always_ff @(posedge clk) begin
		idx_s1  <= raddr;
		vbit_s1 <= valid_q[raddr];
		if (in_acc) begin
			key_q.text_hash <= text_hash;
			key_q.font_id   <= font_id;
			key_q.font_size <= font_size;
			res_hit_q       <= 1'b0;
			res_slot_q      <= '0;
			res_evicted_q   <= 1'b0;
			res_count_q     <= '0;
		end
		if (state_q == ST_UPDATE) begin
			res_hit_q     <= sres.found;
			res_slot_q    <= 6'(upd_slot);
			res_evicted_q <= upd_evict;
			res_count_q   <= 7'(count_next);
		end
		if (state_q == ST_DONE && out_free) begin
			hit         <= res_hit_q;
			slot        <= res_slot_q;
			evicted     <= res_evicted_q;
			entry_count <= res_count_q;
		end
	end

	assign scan.pv   = pv_s1;
	assign scan.idx  = idx_s1;
	assign scan.vbit = vbit_s1;

	tchae_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (state_q == ST_UPDATE),
		.waddr (upd_slot),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	tchae_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.key    (key_q),
		.acc    (acc_q),
		.scan   (scan),
		.entry  (rd_entry),
		.res    (sres)
	);

	// The entry count always equals the number of valid slots.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("entry count differs from valid bit population");

	// An eviction only happens when the table is full.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && upd_evict) |-> count_q == CNT_W'(ENTRIES))
		else $error("eviction with a free slot present");

	// A hit never reports an eviction.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && sres.found) |-> !upd_evict && !upd_grow)
		else $error("hit combined with an eviction or a fill");

	// Every lookup advances the access counter by one.
	a_acc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> acc_q == $past(acc_q) + 1'b1)
		else $error("access counter did not advance");

	// No result is produced while the output register is still stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(hit) && $stable(slot))
		else $error("pending result overwritten");

endmodule

// ----- tb/tb_tagged_cache_hit_age_eviction_unit.sv -----
// Self-checking testbench for the tagged cache hit-age eviction unit.
module tb_tagged_cache_hit_age_eviction_unit;
	import tchae_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_ITEMS  = 150;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int POOL_SIZE    = 96;
	localparam int HOT_KEYS     = 8;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PRINT_LIMIT  = 100;

	// One result beat as the block reports it.
	typedef struct packed {
		logic       hit;
		logic [5:0] slot;
		logic       evicted;
		logic [6:0] entry_count;
	} lookup_result_t;

	// One row of the directed stimulus.
	typedef struct packed {
		logic           op;
		key_t           k;
		logic           typed;
		lookup_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [63:0] text_hash;
	logic [15:0] font_id;
	logic [15:0] font_size;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [5:0]  slot;
	logic        evicted;
	logic [6:0]  entry_count;

	// Typed expectation that travels with the current input beat.
	logic           beat_typed;
	lookup_result_t beat_typed_res;

	// Shadow copy of the tag store.
	logic               tag_valid [ENTRIES];
	key_t               tag_key   [ENTRIES];
	logic [HITS_W-1:0]  tag_hits  [ENTRIES];
	logic [STAMP_W-1:0] tag_stamp [ENTRIES];
	logic [STAMP_W-1:0] access_cnt;

	lookup_result_t pending_results [$];
	stim_row_t      dir_rows [$];
	key_t           key_pool [POOL_SIZE];

	int  err_count   = 0;
	int  result_num  = 0;
	int  cycle_count = 0;
	bit  quiet       = 1'b0;
	bit  hold_req    = 1'b0;

	tagged_cache_hit_age_eviction_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.text_hash   (text_hash),
		.font_id     (font_id),
		.font_size   (font_size),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.slot        (slot),
		.evicted     (evicted),
		.entry_count (entry_count)
	);

	// Clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tagged_cache_hit_age_eviction_unit: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (err_count < PRINT_LIMIT)
			$display("ERROR: %s", msg);
		err_count++;
	endtask

	// Applies one beat to the shadow tag store and returns the result it produces.
	function automatic lookup_result_t cache_access(input logic op, input key_t k);
		lookup_result_t r;
		int found_at;
		int free_at;
		int victim;
		int idx;
		int n;
		logic [STAMP_W-1:0] age;
		logic [STAMP_W-1:0] score;
		logic [STAMP_W-1:0] best_score;
		r = '0;
		if (op == CMD_CLEAR) begin
			for (int i = 0; i < ENTRIES; i++)
				tag_valid[i] = 1'b0;
			return r;
		end
		found_at = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (found_at < 0 && tag_valid[i] && tag_key[i] == k)
				found_at = i;
		if (found_at >= 0) begin
			// Hit: bump the saturating count and restamp.
			idx = found_at;
			r.hit = 1'b1;
			if (tag_hits[idx] < HIT_MAX)
				tag_hits[idx] = tag_hits[idx] + 1'b1;
			access_cnt = access_cnt + 1'b1;
			tag_stamp[idx] = access_cnt;
		end else begin
			free_at = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (free_at < 0 && !tag_valid[i])
					free_at = i;
			if (free_at >= 0) begin
				idx = free_at;
			end else begin
				// Table full: the smallest score goes, lowest slot on a tie.
				victim = 0;
				best_score = '0;
				for (int i = 0; i < ENTRIES; i++) begin
					age = access_cnt - tag_stamp[i];
					score = STAMP_W'(tag_hits[i]) * SCORE_WEIGHT + age;
					if (i == 0 || score < best_score) begin
						best_score = score;
						victim = i;
					end
				end
				idx = victim;
				r.evicted = 1'b1;
			end
			access_cnt = access_cnt + 1'b1;
			tag_valid[idx] = 1'b1;
			tag_key[idx]   = k;
			tag_hits[idx]  = HITS_W'(1);
			tag_stamp[idx] = access_cnt;
		end
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (tag_valid[i])
				n++;
		r.slot = idx[5:0];
		r.entry_count = n[6:0];
		return r;
	endfunction

	// Input and output monitor, sampled at the rising edge.
	always @(posedge clk) begin
		lookup_result_t got;
		lookup_result_t want;
		lookup_result_t pred;
		key_t k;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{hit, slot, evicted, entry_count};
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing pending",
						result_num));
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit)
						report_mismatch($sformatf("result %0d: hit %b, want %b",
							result_num, got.hit, want.hit));
					if (got.slot !== want.slot)
						report_mismatch($sformatf("result %0d: slot %0d, want %0d",
							result_num, got.slot, want.slot));
					if (got.evicted !== want.evicted)
						report_mismatch($sformatf("result %0d: evicted %b, want %b",
							result_num, got.evicted, want.evicted));
					if (got.entry_count !== want.entry_count)
						report_mismatch($sformatf("result %0d: entry_count %0d, want %0d",
							result_num, got.entry_count, want.entry_count));
				end
				result_num++;
			end
			if (in_valid && !in_stall) begin
				k = '{text_hash, font_id, font_size};
				pred = cache_access(cmd, k);
				if (beat_typed)
					pending_results.push_back(beat_typed_res);
				else
					pending_results.push_back(pred);
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none when quiet.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15) - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one beat from a falling edge and returns at the falling edge after it is taken.
	task automatic drive_beat(input logic op, input key_t k, input logic typed,
	                          input lookup_result_t res);
		in_valid       <= 1'b1;
		cmd            <= op;
		text_hash      <= k.text_hash;
		font_id        <= k.font_id;
		font_size      <= k.font_size;
		beat_typed     <= typed;
		beat_typed_res <= res;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic add_row(input logic op, input logic [63:0] h, input logic [15:0] f,
	                       input logic [15:0] s, input logic typed, input logic e_hit,
	                       input logic [5:0] e_slot, input logic e_ev, input logic [6:0] e_cnt);
		stim_row_t row;
		row.op    = op;
		row.k     = '{h, f, s};
		row.typed = typed;
		row.res   = '{e_hit, e_slot, e_ev, e_cnt};
		dir_rows.push_back(row);
	endtask

	function automatic key_t rand_key();
		key_t k;
		k.text_hash = {$urandom, $urandom};
		k.font_id   = 16'($urandom_range(0, 65535));
		k.font_size = 16'($urandom_range(0, 65535));
		return k;
	endfunction

	// Stimulus: directed rows, then random beats drawn mostly from a key pool.
	initial begin
		key_t k;
		logic op;
		int pick;
		int gap;
		in_valid       = 1'b0;
		cmd            = CMD_LOOKUP;
		text_hash      = '0;
		font_id        = '0;
		font_size      = '0;
		beat_typed     = 1'b0;
		beat_typed_res = '0;
		access_cnt     = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			tag_valid[i] = 1'b0;
			tag_key[i]   = '0;
			tag_hits[i]  = '0;
			tag_stamp[i] = '0;
		end
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, hits, keys differing in one field, clears.
		add_row(CMD_LOOKUP, 64'h0, 16'h0, 16'h0, 1, 0, 0, 0, 1);
		add_row(CMD_LOOKUP, '1, '1, '1, 1, 0, 1, 0, 2);
		add_row(CMD_LOOKUP, 64'h0, 16'h0, 16'h0, 1, 1, 0, 0, 2);
		add_row(CMD_LOOKUP, 64'h0, 16'hffff, 16'h0, 1, 0, 2, 0, 3);
		add_row(CMD_LOOKUP, 64'h0, 16'h0, 16'hffff, 1, 0, 3, 0, 4);
		add_row(CMD_LOOKUP, 64'h8000_0000_0000_0000, 16'h0, 16'h0, 1, 0, 4, 0, 5);
		add_row(CMD_LOOKUP, '1, '1, '1, 1, 1, 1, 0, 5);
		add_row(CMD_CLEAR, 64'h0, 16'h0, 16'h0, 1, 0, 0, 0, 0);
		add_row(CMD_CLEAR, 64'h0, 16'h0, 16'h0, 1, 0, 0, 0, 0);
		add_row(CMD_LOOKUP, '1, '1, '1, 1, 0, 0, 0, 1);
		add_row(CMD_CLEAR, '1, '1, '1, 1, 0, 0, 0, 0);
		add_row(CMD_LOOKUP, 64'ha5a5_5a5a_0f0f_f0f0, 16'h1234, 16'h000c, 1, 0, 0, 0, 1);
		add_row(CMD_LOOKUP, 64'ha5a5_5a5a_0f0f_f0f0, 16'h1234, 16'h000c, 1, 1, 0, 0, 1);
		add_row(CMD_LOOKUP, 64'ha5a5_5a5a_0f0f_f0f0, 16'h1234, 16'h000d, 1, 0, 1, 0, 2);
		add_row(CMD_LOOKUP, 64'ha5a5_5a5a_0f0f_f0f0, 16'h1235, 16'h000c, 0, 0, 0, 0, 0);
		add_row(CMD_LOOKUP, 64'ha5a5_5a5a_0f0f_f0f1, 16'h1234, 16'h000c, 0, 0, 0, 0, 0);
		add_row(CMD_LOOKUP, 64'h5a5a_a5a5_f0f0_0f0f, 16'hedcb, 16'hfff3, 0, 0, 0, 0, 0);
		add_row(CMD_LOOKUP, 64'ha5a5_5a5a_0f0f_f0f0, 16'h1234, 16'h000d, 0, 0, 0, 0, 0);
		add_row(CMD_LOOKUP, 64'h0000_0000_0000_0001, 16'h0001, 16'h0001, 0, 0, 0, 0, 0);
		add_row(CMD_LOOKUP, 64'h7fff_ffff_ffff_ffff, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0);
		foreach (dir_rows[i])
			drive_beat(dir_rows[i].op, dir_rows[i].k, dir_rows[i].typed, dir_rows[i].res);

		// Pool of keys, the first few reused often so they build up hit counts.
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = rand_key();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
			if (n == HOLD_AT)
				hold_req = 1'b1;
			pick = $urandom_range(0, 199);
			op = CMD_LOOKUP;
			if (pick == 0) begin
				op = CMD_CLEAR;
				k = rand_key();
			end else if (pick < 16) begin
				k = rand_key();
			end else if (pick < 30) begin
				// Near miss: a pool key with one bit of one field flipped.
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				case ($urandom_range(0, 2))
					0: k.text_hash ^= 64'd1 << $urandom_range(0, 63);
					1: k.font_id   ^= 16'd1 << $urandom_range(0, 15);
					default: k.font_size ^= 16'd1 << $urandom_range(0, 15);
				endcase
			end else if ($urandom_range(0, 1) == 0) begin
				k = key_pool[$urandom_range(0, HOT_KEYS - 1)];
			end else begin
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			end
			if (!quiet && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 15);
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			drive_beat(op, k, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tagged_cache_hit_age_eviction_unit: match");
		else
			$display("tagged_cache_hit_age_eviction_unit: mismatch");
		$finish;
	end

endmodule
